### rtl/pige_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pige_pkg: shared types and constants of the packet identifier gap encoder
// Holds the request and result payloads, the command codes and the word
// bundle that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package pige_pkg;

    // Command codes carried by a request.
    typedef enum logic [1:0] {
        CMD_PACKET   = 2'd0,
        CMD_FIN_MARK = 2'd1,
        CMD_START    = 2'd2,
        CMD_FINISH   = 2'd3
    } command_t;

    // Code word constants.
    localparam logic [14:0] RUN_CAP      = 15'h7fff;
    localparam logic [15:0] SHORT_LIMIT  = 16'h3fff;
    localparam logic [15:0] TAG_FORWARD  = 16'h8000;
    localparam logic [15:0] TAG_BACKWARD = 16'hc000;
    localparam logic [15:0] ESCAPE_WORD  = 16'hffff;

    // Most code words one request can cause.
    localparam int MAX_WORDS = 3;

    // One incoming request.
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] packet_ipid;
        logic [31:0] ack_number;
        logic [31:0] fin_sequence;
    } pige_in_t;

    // One outgoing result.
    typedef struct packed {
        logic [15:0] code_word;
        logic        last_word;
    } pige_out_t;

    // All code words caused by one request.
    typedef struct packed {
        logic [1:0]                  word_cnt;
        logic [MAX_WORDS-1:0][15:0]  words;
    } pige_bundle_t;

    // Status of the bundle queue seen by its neighbors.
    typedef struct packed {
        logic full;
        logic nonempty;
    } pige_qstat_t;

endpackage : pige_pkg
`default_nettype wire

### rtl/pige_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pige_front: request classification and encoder state
// Updates the last identifier, run count and fin state for each accepted
// request and forms the bundle of code words that the request causes.
// ----------------------------------------------------------------------------
module pige_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire pige_pkg::pige_in_t     request,
    output logic                        bundle_push,
    output pige_pkg::pige_bundle_t      bundle
);
    import pige_pkg::*;

    logic [15:0] last_ipid_reg, last_ipid_next;
    logic [14:0] run_count_reg, run_count_next;
    logic        fin_armed_reg, fin_armed_next;
    logic [31:0] fin_seq_reg, fin_seq_next;

    logic [31:0] ack_diff;
    logic        fin_ack;
    logic [15:0] gap;
    logic [15:0] delta;

    // Encoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ipid_reg <= '0;
            run_count_reg <= '0;
            fin_armed_reg <= 1'b0;
            fin_seq_reg   <= '0;
        end
        else if (accept)
        begin
            last_ipid_reg <= last_ipid_next;
            run_count_reg <= run_count_next;
            fin_armed_reg <= fin_armed_next;
            fin_seq_reg   <= fin_seq_next;
        end
    end

    // A packet that acknowledges the armed fin plus one or two is skipped.
    assign ack_diff = request.ack_number - fin_seq_reg;
    assign fin_ack  = fin_armed_reg && (ack_diff == 32'd1 || ack_diff == 32'd2);

    // Identifier gap and its backward magnitude, both modulo 65536.
    assign gap   = request.packet_ipid - last_ipid_reg;
    assign delta = 16'd0 - gap;

    // Next state and the words this request causes.
    always_comb
    begin
        logic [1:0] n;
        n              = 2'd0;
        bundle.words   = '0;
        last_ipid_next = last_ipid_reg;
        run_count_next = run_count_reg;
        fin_armed_next = fin_armed_reg;
        fin_seq_next   = fin_seq_reg;

        unique case (command_t'(request.command))
            CMD_FIN_MARK:
            begin
                fin_seq_next   = request.fin_sequence;
                fin_armed_next = 1'b1;
            end
            CMD_START:
            begin
                last_ipid_next = request.packet_ipid;
                run_count_next = '0;
                fin_armed_next = 1'b0;
                fin_seq_next   = '0;
            end
            CMD_FINISH:
            begin
                if (run_count_reg != '0)
                begin
                    bundle.words[0] = {1'b0, run_count_reg};
                    n               = 2'd1;
                end
                run_count_next = '0;
            end
            CMD_PACKET:
            begin
                if (!fin_ack)
                begin
                    last_ipid_next = request.packet_ipid;
                    if (gap == 16'd1)
                    begin
                        // Extend the run; a full run is sent and restarts at one.
                        if (run_count_reg != RUN_CAP)
                        begin
                            run_count_next = run_count_reg + 15'd1;
                        end
                        else
                        begin
                            bundle.words[0] = {1'b0, run_count_reg};
                            n               = 2'd1;
                            run_count_next  = 15'd1;
                        end
                    end
                    else
                    begin
                        // Flush a pending run ahead of the gap word.
                        if (run_count_reg != '0)
                        begin
                            bundle.words[0] = {1'b0, run_count_reg};
                            n               = 2'd1;
                        end
                        run_count_next = '0;
                        if (!gap[15] && gap < SHORT_LIMIT)
                        begin
                            bundle.words[n] = TAG_FORWARD | gap;
                            n               = n + 2'd1;
                        end
                        else if (gap[15] && delta < SHORT_LIMIT)
                        begin
                            bundle.words[n] = TAG_BACKWARD | delta;
                            n               = n + 2'd1;
                        end
                        else
                        begin
                            bundle.words[n] = ESCAPE_WORD;
                            n               = n + 2'd1;
                            bundle.words[n] = gap;
                            n               = n + 2'd1;
                        end
                    end
                end
            end
            default:
            begin
                n = 2'd0;
            end
        endcase

        bundle.word_cnt = n;
    end

    // Only requests that cause words enter the queue.
    assign bundle_push = accept && (bundle.word_cnt != 2'd0);

endmodule : pige_front
`default_nettype wire

### rtl/pige_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pige_queue: bundle queue between the front and the back part
// A small register queue that lets the front keep taking requests while
// the back part is still sending the words of earlier ones.
// ----------------------------------------------------------------------------
module pige_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire pige_pkg::pige_bundle_t wr_data,
    input  wire logic                   rd_en,
    output pige_pkg::pige_bundle_t      rd_data,
    output pige_pkg::pige_qstat_t       status
);
    import pige_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pige_bundle_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Storage is written without reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointer and fill count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Pointers wrap at the depth, which need not be a power of two.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // Fill count follows writes and reads.
    always_comb
    begin
        case ({wr_en, rd_en})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    assign rd_data         = mem_reg[rd_ptr_reg];
    assign status.full     = (cnt_reg == CNT_W'(DEPTH));
    assign status.nonempty = (cnt_reg != '0);

endmodule : pige_queue
`default_nettype wire

### rtl/pige_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pige_back: word sequencer and result register
// Takes one bundle at a time from the queue and presents its words one
// by one, marking the final word of the bundle.
// ----------------------------------------------------------------------------
module pige_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pige_pkg::pige_qstat_t  qstat,
    input  wire pige_pkg::pige_bundle_t q_data,
    output logic                        q_pop,
    output logic                        empty,
    input  wire logic                   pop,
    output pige_pkg::pige_out_t         result
);
    import pige_pkg::*;

    pige_bundle_t cur_reg;
    logic         valid_reg, valid_next;
    logic [1:0]   idx_reg, idx_next;
    logic         at_last;
    logic         taken;

    assign at_last = (idx_reg == cur_reg.word_cnt - 2'd1);
    assign taken   = pop && valid_reg;

    // Load a new bundle when idle or when the final word is taken.
    assign q_pop = qstat.nonempty && (!valid_reg || (taken && at_last));

    // Next word index and holding flag.
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (taken)
        begin
            if (at_last)
            begin
                valid_next = 1'b0;
            end
            idx_next = idx_reg + 2'd1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Current bundle payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    assign empty            = !valid_reg;
    assign result.code_word = cur_reg.words[idx_reg];
    assign result.last_word = at_last;

endmodule : pige_back
`default_nettype wire

### rtl/packet_id_gap_run_encoder_core.sv
`default_nettype none
// Path: the first word of a request passes through the bundle queue and then
// the result register before it is on the outputs, when the result side is idle.
// Throughput: one request per cycle is accepted while full is low; words
// leave at one per cycle while pop is held, each word of a request in turn.
// The bundle queue (DEPTH entries) absorbs the difference before full rises.
// Reset: asynchronous, active low; clears encoder state and empties the queue.
// ----------------------------------------------------------------------------
// packet_id_gap_run_encoder_core: packet identifier gap and run encoder
// Encodes packet identifiers as run counts, tagged gaps or escaped raw gaps,
// with a front part that classifies requests and a back part that sends words.
// ----------------------------------------------------------------------------
module packet_id_gap_run_encoder_core #(
    parameter int DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire pige_pkg::pige_in_t  request,
    output logic                     empty,
    input  wire logic                pop,
    output pige_pkg::pige_out_t      result
);
    import pige_pkg::*;

    logic         accept;
    logic         bundle_push;
    pige_bundle_t bundle;
    pige_bundle_t q_data;
    pige_qstat_t  qstat;
    logic         q_pop;

    assign full   = qstat.full;
    assign accept = push && !qstat.full;

    // Front part: state update and classification.
    pige_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .request     (request),
        .bundle_push (bundle_push),
        .bundle      (bundle)
    );

    // Queue between front and back.
    pige_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bundle_push),
        .wr_data (bundle),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .status  (qstat)
    );

    // Back part: word sequencing.
    pige_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .q_data (q_data),
        .q_pop  (q_pop),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // A bundle is never written into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) bundle_push |-> !qstat.full)
        else $error("bundle written into full queue");

    // The back part never reads an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> qstat.nonempty)
        else $error("bundle read from empty queue");

    // A request that causes words is followed by a shown result.
    assert property (@(posedge clk) disable iff (!rst_n) bundle_push |-> ##2 !empty)
        else $error("no result after request with words");

    // Only requests that cause words enter the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        bundle_push |-> (bundle.word_cnt != 2'd0))
        else $error("empty bundle queued");

endmodule : packet_id_gap_run_encoder_core
`default_nettype wire
